// ===== rtl/assert_macros.svh =====
// assertion macros shared by the dns query name parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check, ignored while reset is asserted
`define DQP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dqp assertion failed");
// concurrent check that holds through reset as well
`define DQP_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dqp assertion failed");
`else
`define DQP_ASSERT(lbl, clk, rst_n, prop)
`define DQP_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/dqp_pkg.sv =====
// types and constants of the dns query name parser
`timescale 1ns / 1ps

package dqp_pkg;

    localparam int          POS_W         = 6;
    localparam logic [5:0]  POS_MAX       = 6'd63;
    localparam logic [5:0]  QNAME_START   = 6'd12;
    localparam logic [6:0]  MIN_LENGTH    = 7'd17;
    localparam logic [7:0]  LONGEST_LABEL = 8'd63;
    localparam logic [7:0]  DOT_CHAR      = 8'h2E;
    localparam int          QR_BIT        = 15;

    localparam logic        KIND_CHAR     = 1'b0;
    localparam logic        KIND_SUMMARY  = 1'b1;

    localparam int          FIFO_DEPTH    = 4;
    localparam int          FIFO_AW       = 2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [4:0]  char_index;
        logic [15:0] txid_out;
        logic [15:0] query_type;
        logic        is_response;
        logic [5:0]  name_length;
        logic        counted;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic    char_vld;
        logic    sum_vld;
        t_result chr;
        t_result sum;
    } t_push;

endpackage

// ===== rtl/dqp_if.sv =====
// handshake channels of the dns query name parser
`timescale 1ns / 1ps

interface dqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       end_of_packet;

    modport source (output valid, output pkt_byte, output end_of_packet, input ready);
    modport sink   (input valid, input pkt_byte, input end_of_packet, output ready);
endinterface

interface dqp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  name_char;
    logic [4:0]  char_index;
    logic [15:0] txid_out;
    logic [15:0] query_type;
    logic        is_response;
    logic [5:0]  name_length;
    logic        counted;
    logic        last_of_run;

    modport source (
        output valid, output kind, output name_char, output char_index,
        output txid_out, output query_type, output is_response,
        output name_length, output counted, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input name_char, input char_index,
        input txid_out, input query_type, input is_response,
        input name_length, input counted, input last_of_run,
        output ready
    );
endinterface

// ===== rtl/dns_query_name_parser.sv =====
// top level of the dns query name parser
`timescale 1ns / 1ps
// usage
//   i_in carries one byte of a dns message per word, end_of_packet set on
//   the final byte. o_out carries results: one character word (kind 0) for
//   every domain character or separating dot that fits the domain text, and one summary word (kind 1,
//   last_of_run set) after the final byte with txid, qtype, qr bit, domain
//   length and the counted flag.
//   results: each result is written into the queue before it is offered
//   on o_out; a summary that follows a character leaves after it.
//   throughput: one byte per cycle while i_in.ready is high; each byte
//   is decoded by the parser state registers, and results wait in a
//   four-entry queue. i_in.ready stays high while the queue has two free
//   entries, so a byte that makes both a character and a summary fits.
//   receiver stall: the queue fills, then i_in.ready drops until o_out
//   drains; no result is lost or repeated.
//   reset: synchronous, active low; the parser returns to the header phase
//   with all counters clear and the queue empties. after each summary the
//   parser clears itself for the next message.

module dns_query_name_parser import dqp_pkg::*; #(
    parameter int CAPTURE_BYTES = 44,
    parameter int DOMAIN_BYTES  = 32,
    parameter int LABEL_LIMIT   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dqp_in_if.sink           i_in,
    dqp_out_if.source        o_out
);

    t_push   w_push;
    t_result w_head;
    logic    w_space;
    logic    w_take;
    logic    w_valid;

    // a byte is taken whenever the queue can absorb its worst case
    assign i_in.ready = w_space;
    assign w_take     = i_in.valid & w_space;

    dqp_parser #(
        .CAPTURE_BYTES (CAPTURE_BYTES),
        .DOMAIN_BYTES  (DOMAIN_BYTES),
        .LABEL_LIMIT   (LABEL_LIMIT)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_in.pkt_byte),
        .i_last  (i_in.end_of_packet),
        .o_push  (w_push)
    );

    // result queue decouples the decoder from a stalling receiver
    dqp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (o_out.ready),
        .o_valid (w_valid),
        .o_space (w_space),
        .o_head  (w_head)
    );

    // head of the queue drives the output word
    assign o_out.valid       = w_valid;
    assign o_out.kind        = w_head.kind;
    assign o_out.name_char   = w_head.name_char;
    assign o_out.char_index  = w_head.char_index;
    assign o_out.txid_out    = w_head.txid_out;
    assign o_out.query_type  = w_head.query_type;
    assign o_out.is_response = w_head.is_response;
    assign o_out.name_length = w_head.name_length;
    assign o_out.counted     = w_head.counted;
    assign o_out.last_of_run = w_head.last_of_run;

endmodule

// ===== rtl/dqp_parser.sv =====
// per-byte header and qname decode state with result generation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqp_parser import dqp_pkg::*; #(
    parameter int CAPTURE_BYTES = 44,
    parameter int DOMAIN_BYTES  = 32,
    parameter int LABEL_LIMIT   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_QTYPE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [6:0] CAP_LIM = 7'(CAPTURE_BYTES);
    localparam logic [8:0] DOM_LIM = 9'(DOMAIN_BYTES);
    localparam logic [6:0] LBL_LIM = 7'(LABEL_LIMIT);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_phase, n_phase;
    logic [5:0]       r_rem, n_rem;
    logic [4:0]       r_labels, n_labels;
    logic [5:0]       r_dc, n_dc;
    logic [15:0]      r_txid, n_txid;
    logic [15:0]      r_flags, n_flags;
    logic [15:0]      r_qtype, n_qtype;
    logic [5:0]       r_stop, n_stop;
    logic             r_len_ok, n_len_ok;

    logic       emit;
    logic [7:0] ch;
    logic       do_stop;
    logic [6:0] stop_at;
    logic [6:0] pos7;
    logic [5:0] rem_dec;
    logic       room;

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_labels = r_labels;
        n_dc     = r_dc;
        n_txid   = r_txid;
        n_flags  = r_flags;
        n_qtype  = r_qtype;
        n_stop   = r_stop;
        n_len_ok = r_len_ok;
        emit     = 1'b0;
        ch       = 8'd0;
        do_stop  = 1'b0;
        stop_at  = 7'd0;
        pos7     = {1'b0, r_pos};
        rem_dec  = (r_rem != 6'd0) ? r_rem - 6'd1 : 6'd0;
        room     = (9'(r_dc) < DOM_LIM);
        o_push   = '0;

        if (i_take) begin
            if (pos7 < CAP_LIM) begin
                case (r_pos)
                    6'd0:    n_txid[15:8]  = i_byte;
                    6'd1:    n_txid[7:0]   = i_byte;
                    6'd2:    n_flags[15:8] = i_byte;
                    6'd3:    n_flags[7:0]  = i_byte;
                    default: ;
                endcase

                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos == QNAME_START - 6'd1) n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (i_byte == 8'd0 || i_byte > LONGEST_LABEL) begin
                            do_stop = 1'b1;
                            stop_at = pos7;
                        end else begin
                            if (r_dc != 6'd0 && room) begin
                                emit = 1'b1;
                                ch   = DOT_CHAR;
                            end
                            n_labels = r_labels + 5'd1;
                            n_rem    = i_byte[5:0];
                            n_phase  = PH_LABEL;
                        end
                    end
                    PH_LABEL: begin
                        // past a full domain the label is still skipped
                        if (room) begin
                            emit = 1'b1;
                            ch   = i_byte;
                        end
                        n_rem = rem_dec;
                        if (rem_dec == 6'd0) begin
                            if (7'(r_labels) >= LBL_LIM) begin
                                do_stop = 1'b1;
                                stop_at = pos7 + 7'd1;
                            end else begin
                                n_phase = PH_LEN;
                            end
                        end
                    end
                    PH_QTYPE: begin
                        if (pos7 == {1'b0, r_stop} + 7'd1) begin
                            n_qtype[15:8] = i_byte;
                        end else if (pos7 == {1'b0, r_stop} + 7'd2) begin
                            n_qtype[7:0] = i_byte;
                            n_phase      = PH_DONE;
                        end
                    end
                    default: ;
                endcase

                if (do_stop) begin
                    n_stop  = stop_at[5:0];
                    n_phase = (stop_at + 7'd2 < CAP_LIM) ? PH_QTYPE : PH_DONE;
                end
            end

            if (pos7 + 7'd1 >= MIN_LENGTH) n_len_ok = 1'b1;
            if (r_pos != POS_MAX) n_pos = r_pos + 6'd1;

            if (emit) n_dc = r_dc + 6'd1;

            o_push.char_vld       = emit;
            o_push.chr.kind       = KIND_CHAR;
            o_push.chr.name_char  = ch;
            o_push.chr.char_index = r_dc[4:0];

            // summary reflects this byte's updates
            o_push.sum_vld         = i_last;
            o_push.sum.kind        = KIND_SUMMARY;
            o_push.sum.txid_out    = n_txid;
            o_push.sum.query_type  = n_qtype;
            o_push.sum.is_response = n_flags[QR_BIT];
            o_push.sum.name_length = n_dc;
            o_push.sum.counted     = n_len_ok & ~n_flags[QR_BIT];
            o_push.sum.last_of_run = 1'b1;

            if (i_last) begin
                n_pos    = '0;
                n_phase  = PH_HEADER;
                n_rem    = '0;
                n_labels = '0;
                n_dc     = '0;
                n_txid   = '0;
                n_flags  = '0;
                n_qtype  = '0;
                n_stop   = '0;
                n_len_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= PH_HEADER;
            r_rem    <= '0;
            r_labels <= '0;
            r_dc     <= '0;
            r_txid   <= '0;
            r_flags  <= '0;
            r_qtype  <= '0;
            r_stop   <= '0;
            r_len_ok <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_labels <= n_labels;
            r_dc     <= n_dc;
            r_txid   <= n_txid;
            r_flags  <= n_flags;
            r_qtype  <= n_qtype;
            r_stop   <= n_stop;
            r_len_ok <= n_len_ok;
        end
    end

    // a summary always leaves the decoder ready for a fresh message
    `DQP_ASSERT(a_clear_after_summary, i_clk, i_rst_n, o_push.sum_vld |=> (r_pos == 6'd0 && r_dc == 6'd0 && r_phase == PH_HEADER))
    // characters only while the domain text has room
    `DQP_ASSERT(a_char_in_room, i_clk, i_rst_n, o_push.char_vld |-> (9'(r_dc) < DOM_LIM))
    // once the name has stopped, its stop position lies at or past the qname start
    `DQP_ASSERT(a_stop_no_label, i_clk, i_rst_n, (r_phase == PH_QTYPE) |-> (r_stop >= QNAME_START))

endmodule

// ===== rtl/dqp_out_fifo.sv =====
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqp_out_fifo import dqp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_space,
    output t_result o_head
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count, n_count;
    logic [FIFO_AW-1:0] w_sum_addr;
    logic [FIFO_AW:0]   w_push_n;
    logic               w_pop;

    assign o_valid    = (r_count != '0);
    assign o_space    = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign o_head     = r_mem[r_rd_ptr];
    assign w_pop      = i_pop & o_valid;
    assign w_sum_addr = i_push.char_vld ? r_wr_ptr + {{(FIFO_AW-1){1'b0}}, 1'b1} : r_wr_ptr;
    assign w_push_n   = (FIFO_AW + 1)'(i_push.char_vld) + (FIFO_AW + 1)'(i_push.sum_vld);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(w_push_n);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(w_pop);
        n_count  = r_count + w_push_n - (FIFO_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.char_vld) r_mem[r_wr_ptr] <= i_push.chr;
        if (i_push.sum_vld)  r_mem[w_sum_addr] <= i_push.sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `DQP_ASSERT(a_no_overflow, i_clk, i_rst_n, r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    // a push only lands where two free slots were promised
    `DQP_ASSERT(a_push_has_room, i_clk, i_rst_n, (i_push.char_vld || i_push.sum_vld) |-> o_space)
    // occupancy tracks the two pointers
    `DQP_ASSERT(a_ptr_count, i_clk, i_rst_n, FIFO_AW'(r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])

endmodule

// ===== dv/tb.sv =====
// self-checking testbench of the dns query name parser
`timescale 1ns / 1ps

module tb import dqp_pkg::*; ();

    localparam int CAPTURE_BYTES = 44;
    localparam int DOMAIN_BYTES  = 32;
    localparam int LABEL_LIMIT   = 16;
    localparam int STIM_BYTES    = 1100;
    localparam int MAX_WAIT      = 16;
    localparam int SETTLE_CYCLES = 20;
    // bound on the run, above the slowest legal one: two results per byte, each at the longest stall
    localparam int CYCLE_LIMIT   = 400000;

    // where the decoder stands inside one message
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_LENGTH,
        ST_LABEL,
        ST_QTYPE,
        ST_DONE
    } t_name_state;

    // one byte waiting to go out, drain asks for an empty result store first
    typedef struct {
        logic [7:0] data;
        logic       eop;
        bit         drain;
    } t_pkt_word;

    logic i_clk;
    logic i_rst_n;

    dqp_in_if  in_if ();
    dqp_out_if out_if ();

    dns_query_name_parser #(
        .CAPTURE_BYTES (CAPTURE_BYTES),
        .DOMAIN_BYTES  (DOMAIN_BYTES),
        .LABEL_LIMIT   (LABEL_LIMIT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // decoder state of the prediction
    logic [5:0]  nm_pos;
    t_name_state nm_state;
    logic [5:0]  nm_label_left;
    logic [4:0]  nm_label_count;
    logic [5:0]  nm_text_len;
    logic [15:0] nm_txid;
    logic [15:0] nm_flags;
    logic [15:0] nm_qtype;
    logic [5:0]  nm_stop;
    logic        nm_long_enough;

    t_result   decoded_q[$];
    t_pkt_word byte_q[$];
    logic [7:0] msg_bytes[$];

    t_result   want;
    t_pkt_word nxt;
    bit        in_taken;
    bit        out_taken;
    bit        in_burst;
    bit        out_burst;
    int        in_gap;
    int        out_stall;
    int        total_bytes;
    int        bytes_in;
    int        msg_count;
    int        chars_seen;
    int        summaries_seen;
    int        mismatches;
    int        cycles;

    task clear_name();
        nm_pos         = '0;
        nm_state       = ST_HEADER;
        nm_label_left  = '0;
        nm_label_count = '0;
        nm_text_len    = '0;
        nm_txid        = '0;
        nm_flags       = '0;
        nm_qtype       = '0;
        nm_stop        = '0;
        nm_long_enough = 1'b0;
    endtask

    // name ends at byte at, qtype follows only if both bytes fit the window
    task close_name(input int unsigned at);
        nm_stop  = 6'(at);
        nm_state = (at + 2 < CAPTURE_BYTES) ? ST_QTYPE : ST_DONE;
    endtask

    // advance the decoder by one byte and queue the results it makes
    task decode_byte(input logic [7:0] b, input logic eop);
        int unsigned p;
        logic        make_char;
        logic [7:0]  ch;
        t_result     r;
        p         = nm_pos;
        make_char = 1'b0;
        ch        = '0;
        if (p < CAPTURE_BYTES) begin
            case (p)
                0: nm_txid[15:8]  = b;
                1: nm_txid[7:0]   = b;
                2: nm_flags[15:8] = b;
                3: nm_flags[7:0]  = b;
                default: ;
            endcase
            case (nm_state)
                ST_HEADER: begin
                    if (p + 1 == QNAME_START) nm_state = ST_LENGTH;
                end
                ST_LENGTH: begin
                    if (b == 8'd0 || b > LONGEST_LABEL) begin
                        close_name(p);
                    end else begin
                        // dot only between labels and while the text has room
                        if (nm_text_len > 0 && nm_text_len < DOMAIN_BYTES) begin
                            make_char = 1'b1;
                            ch        = DOT_CHAR;
                        end
                        nm_label_count = nm_label_count + 1'b1;
                        nm_label_left  = b[5:0];
                        nm_state       = ST_LABEL;
                    end
                end
                ST_LABEL: begin
                    // a full text still skips the rest of the label
                    if (nm_text_len < DOMAIN_BYTES) begin
                        make_char = 1'b1;
                        ch        = b;
                    end
                    if (nm_label_left > 0) nm_label_left = nm_label_left - 1'b1;
                    if (nm_label_left == 0) begin
                        if (nm_label_count >= LABEL_LIMIT) close_name(p + 1);
                        else nm_state = ST_LENGTH;
                    end
                end
                ST_QTYPE: begin
                    if (p == nm_stop + 1) begin
                        nm_qtype[15:8] = b;
                    end else if (p == nm_stop + 2) begin
                        nm_qtype[7:0] = b;
                        nm_state      = ST_DONE;
                    end
                end
                default: ;
            endcase
        end
        if (p + 1 >= MIN_LENGTH) nm_long_enough = 1'b1;
        if (nm_pos < POS_MAX) nm_pos = nm_pos + 1'b1;

        if (make_char) begin
            r            = '0;
            r.kind       = KIND_CHAR;
            r.name_char  = ch;
            r.char_index = nm_text_len[4:0];
            decoded_q.push_back(r);
            nm_text_len  = nm_text_len + 1'b1;
        end
        if (eop) begin
            r             = '0;
            r.kind        = KIND_SUMMARY;
            r.txid_out    = nm_txid;
            r.query_type  = nm_qtype;
            r.is_response = nm_flags[QR_BIT];
            r.name_length = nm_text_len;
            r.counted     = nm_long_enough && !nm_flags[QR_BIT];
            r.last_of_run = 1'b1;
            decoded_q.push_back(r);
            clear_name();
        end
    endtask

    task check_field(input string what, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                         what, cycles, exp_v, act_v);
        end
    endtask

    // queue msg_bytes as one message, end of packet on its last byte
    task send_message(input bit drain);
        t_pkt_word w;
        for (int i = 0; i < msg_bytes.size(); i++) begin
            w.data  = msg_bytes[i];
            w.eop   = (i == msg_bytes.size() - 1);
            w.drain = drain && (i == 0);
            byte_q.push_back(w);
        end
        msg_bytes.delete();
        msg_count++;
    endtask

    // mostly well-formed queries with random content, some noise and cut messages
    task build_message();
        int unsigned style;
        int unsigned n_labels;
        int unsigned len;
        int unsigned cut;
        style = $urandom_range(0, 19);
        if (style < 3) begin
            repeat ($urandom_range(1, 80)) msg_bytes.push_back(8'($urandom));
        end else begin
            repeat (12) msg_bytes.push_back(8'($urandom));
            // one-byte labels are the only way to reach the label limit in the window
            n_labels = (style == 3) ? LABEL_LIMIT + $urandom_range(0, 2)
                                    : $urandom_range(1, 4);
            for (int i = 0; i < n_labels; i++) begin
                if (style == 3)     len = 1;
                else if (style < 7) len = $urandom_range(1, 63);
                else                len = $urandom_range(1, 12);
                msg_bytes.push_back(8'(len));
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
            // terminator: root label, or a length byte above the label maximum
            if ($urandom_range(0, 4) == 0) msg_bytes.push_back(8'($urandom_range(64, 255)));
            else msg_bytes.push_back(8'h00);
            msg_bytes.push_back(8'($urandom));
            msg_bytes.push_back(8'($urandom));
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(8'h01);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 30)) msg_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // sender: holds a word until taken, then waits its drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // word still on offer
        end else if (in_gap > 0) begin
            in_if.valid <= 1'b0;
            in_gap      <= in_gap - 1;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && decoded_q.size() > 0)) begin
            nxt = byte_q.pop_front();
            in_if.valid         <= 1'b1;
            in_if.pkt_byte      <= nxt.data;
            in_if.end_of_packet <= nxt.eop;
            in_gap              <= draw_wait(in_burst);
            if (nxt.eop) in_burst <= ($urandom_range(0, 3) == 0);
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // receiver: after each taken result it stalls for a drawn number of cycles
    always @(negedge i_clk) begin
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0) out_burst <= !out_burst;
            out_stall = draw_wait(out_burst);
        end
        if (out_stall > 0) begin
            out_if.ready <= 1'b0;
            out_stall     = out_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // monitor: predict on every taken byte, check every taken result
    always @(posedge i_clk) begin
        in_taken  <= in_if.valid && in_if.ready;
        out_taken <= out_if.valid && out_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (out_if.kind == KIND_SUMMARY) summaries_seen++;
                else chars_seen++;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at cycle %0d, kind %0d",
                                 cycles, out_if.kind);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", want.kind, out_if.kind);
                    check_field("name_char", want.name_char, out_if.name_char);
                    check_field("char_index", want.char_index, out_if.char_index);
                    check_field("txid_out", want.txid_out, out_if.txid_out);
                    check_field("query_type", want.query_type, out_if.query_type);
                    check_field("is_response", want.is_response, out_if.is_response);
                    check_field("name_length", want.name_length, out_if.name_length);
                    check_field("counted", want.counted, out_if.counted);
                    check_field("last_of_run", want.last_of_run, out_if.last_of_run);
                end
            end
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.pkt_byte, in_if.end_of_packet);
                bytes_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[dns_query_name_parser] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.pkt_byte      = '0;
        in_if.end_of_packet = 1'b0;
        out_if.ready        = 1'b0;
        in_taken            = 1'b0;
        out_taken           = 1'b0;
        in_burst            = 1'b0;
        out_burst           = 1'b0;
        in_gap              = 0;
        out_stall           = 0;
        bytes_in            = 0;
        msg_count           = 0;
        chars_seen          = 0;
        summaries_seen      = 0;
        mismatches          = 0;
        cycles              = 0;
        clear_name();

        // message cut on its first byte
        msg_bytes = '{8'hA5};
        send_message(1'b0);
        // response, all-ones txid, name "abc" closed by a length above 63
        msg_bytes = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h61, 8'h62, 8'h63,
                      8'h40, 8'h00, 8'h1C, 8'hFF};
        send_message(1'b0);
        // all-zero query cut inside the header
        msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_message(1'b1);

        while (byte_q.size() < STIM_BYTES) begin
            build_message();
            send_message(msg_count % 12 == 0);
        end
        total_bytes = byte_q.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (bytes_in != total_bytes) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d messages", total_bytes, msg_count);
        $display("checked %0d name characters and %0d summaries, %0d mismatches",
                 chars_seen, summaries_seen, mismatches);
        if (mismatches == 0) begin
            $display("[dns_query_name_parser] OK");
        end else begin
            $display("[dns_query_name_parser] ERROR");
        end
        $finish;
    end

endmodule
